### hw/rtl/tam_pkg.sv
// ----------------------------------------------------------------------------
// tam_pkg: shared types and constants of the tensor axis mean block
// Command codes, state encodings and the effective configuration structure.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int unsigned NUM_DIMS = 4;
  localparam int unsigned DIM_W    = $clog2(NUM_DIMS);
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned SMP_W    = 32;
  localparam int unsigned RIDX_W   = 12;
  localparam int unsigned Q_DEPTH  = 4;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_ACC   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RANK   = 3'd0;
  localparam logic [2:0] CFG_SIZE_0 = 3'd1;
  localparam logic [2:0] CFG_SIZE_1 = 3'd2;
  localparam logic [2:0] CFG_SIZE_2 = 3'd3;
  localparam logic [2:0] CFG_SIZE_3 = 3'd4;
  localparam logic [2:0] CFG_AXIS   = 3'd5;

  typedef enum logic [1:0] {
    CMD_ACC,
    CMD_READ,
    CMD_CLEAR
  } cmd_op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WALK,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ACC,
    B_RDW,
    B_DIV,
    B_SAT,
    B_OUT
  } back_state_e;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [2:0]                           rank;
    logic [DIM_W-1:0]                     axis;
    logic [NUM_DIMS-1:0][SIZE_W-1:0]      size;
  } cfg_t;

  // Command handed from the front to the back; the address travels beside it.
  typedef struct packed {
    cmd_op_e          op;
    logic             bad;
    logic [SMP_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

### hw/rtl/tam_fifo.sv
// ----------------------------------------------------------------------------
// tam_fifo: small command queue
// Register-based first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module tam_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/tam_front.sv
// ----------------------------------------------------------------------------
// tam_front: request intake and index generation
// Walks the dimensions to form the reduced index or the reduced tensor size,
// keeps the position counters and queues one command per request.
// ----------------------------------------------------------------------------
module tam_front import tam_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic [1:0]                     req_type_i,
  input  logic signed [SMP_W-1:0]        sample_i,
  input  logic [RIDX_W-1:0]              read_index_i,
  input  cfg_t                           cfg_i,
  input  logic                           q_full_i,
  output logic                           busy_o,
  output logic                           push_o,
  output cmd_t                           cmd_o,
  output logic [$clog2(OUT_DEPTH)-1:0]   addr_o
);

  localparam int unsigned AW = $clog2(OUT_DEPTH);
  localparam int unsigned SW = AW + 12;

  front_state_e       st_q, st_d;
  logic [1:0]         req_q, req_d;
  logic [SMP_W-1:0]   sample_q, sample_d;
  logic [RIDX_W-1:0]  ri_q, ri_d;
  logic [DIM_W-1:0]   d_q, d_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               over_q, over_d;
  logic [NUM_DIMS-1:0][CNT_W-1:0] cnt_q, cnt_d, cnt_step;

  logic               kept;
  logic [CNT_W-1:0]   addend;
  logic [SW-1:0]      sum;
  logic [31:0]        ri_ext;

  assign kept   = ({1'b0, d_q} < cfg_i.rank) && (d_q != cfg_i.axis);
  assign addend = (req_q == REQ_ACC) ? cnt_q[d_q] : '0;
  assign sum    = SW'(idx_q) * SW'(cfg_i.size[d_q]) + SW'(addend);
  assign ri_ext = 32'(ri_q);

  // Odometer step: the innermost live dimension counts, carries ripple out.
  always_comb begin
    logic             carry;
    logic [CNT_W:0]   nxt;
    carry    = 1'b1;
    cnt_step = cnt_q;
    for (int k = NUM_DIMS - 1; k >= 0; k--) begin
      nxt = {1'b0, cnt_q[k]} + 1'b1;
      if ((k < int'(cfg_i.rank)) && carry) begin
        if (32'(nxt) >= 32'(cfg_i.size[k])) begin
          cnt_step[k] = '0;
        end else begin
          cnt_step[k] = nxt[CNT_W-1:0];
          carry       = 1'b0;
        end
      end
    end
  end

  always_comb begin
    st_d     = st_q;
    req_d    = req_q;
    sample_d = sample_q;
    ri_d     = ri_q;
    d_d      = d_q;
    idx_d    = idx_q;
    over_d   = over_q;
    cnt_d    = cnt_q;
    busy_o   = (st_q != F_IDLE);
    push_o   = 1'b0;
    cmd_o.op     = CMD_CLEAR;
    cmd_o.bad    = 1'b0;
    cmd_o.sample = sample_q;
    addr_o       = idx_q;
    case (req_q)
      REQ_ACC: begin
        cmd_o.op  = CMD_ACC;
        cmd_o.bad = over_q;
      end
      REQ_READ: begin
        cmd_o.op  = CMD_READ;
        cmd_o.bad = (!over_q && (ri_ext >= 32'(idx_q))) || (ri_ext >= 32'(OUT_DEPTH));
        addr_o    = ri_ext[AW-1:0];
      end
      default: ;
    endcase
    unique case (st_q)
      F_IDLE: begin
        if (take_i) begin
          req_d    = req_type_i;
          sample_d = sample_i;
          ri_d     = read_index_i;
          d_d      = '0;
          over_d   = 1'b0;
          idx_d    = (req_type_i == REQ_READ) ? AW'(1) : '0;
          case (req_type_i)
            REQ_ACC, REQ_READ: st_d = F_WALK;
            REQ_CLEAR: begin
              cnt_d = '0;
              st_d  = F_PUSH;
            end
            default: ;
          endcase
        end
      end
      F_WALK: begin
        if (kept) begin
          idx_d  = sum[AW-1:0];
          over_d = over_q || (sum >= SW'(OUT_DEPTH));
        end
        d_d = d_q + 1'b1;
        if (d_q == DIM_W'(NUM_DIMS - 1)) begin
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          push_o = 1'b1;
          st_d   = F_IDLE;
          if (req_q == REQ_ACC) begin
            cnt_d = cnt_step;
          end
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= F_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    sample_q <= sample_d;
    ri_q     <= ri_d;
    d_q      <= d_d;
    idx_q    <= idx_d;
    over_q   <= over_d;
  end

endmodule

### hw/rtl/tam_back.sv
// ----------------------------------------------------------------------------
// tam_back: accumulator memory and mean unit
// Carries out queued commands: read-modify-write, clearing sweep and a
// bit-serial division for the mean, with an output register.
// ----------------------------------------------------------------------------
module tam_back import tam_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  cmd_t                          cmd_i,
  input  logic [$clog2(OUT_DEPTH)-1:0]  addr_i,
  input  logic [SIZE_W-1:0]             div_i,
  output logic                          pop_o,
  output back_stat_t                    stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SMP_W-1:0]              mean_o,
  output logic                          status_o
);

  localparam int unsigned AW = $clog2(OUT_DEPTH);
  localparam int unsigned DCW = $clog2(ACC_W);

  logic [ACC_W-1:0] mem [OUT_DEPTH];
  logic [ACC_W-1:0] rdata_q;

  back_state_e      st_q, st_d;
  logic             init_q, init_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [SMP_W-1:0] sample_q, sample_d;
  logic             neg_q, neg_d;
  logic [ACC_W-1:0] quo_q, quo_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [DCW-1:0]   dcnt_q, dcnt_d;
  logic [SMP_W-1:0] res_q, res_d;
  logic             rst_q, rst_d;
  logic             out_v_q, out_load;
  logic [SMP_W-1:0] mean_q;
  logic             status_q;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [ACC_W-1:0] mem_wd;
  logic [SIZE_W:0]  shifted;

  assign shifted     = {rem_q, quo_q[ACC_W-1]};
  assign stat_o.init_busy = init_q;
  assign out_valid_o = out_v_q;
  assign mean_o      = mean_q;
  assign status_o    = status_q;

  always_comb begin
    st_d     = st_q;
    init_d   = init_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    sample_d = sample_q;
    neg_d    = neg_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    res_d    = res_q;
    rst_d    = rst_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = clr_q;
    mem_wd   = '0;
    mem_re   = 1'b0;
    mem_ra   = addr_i;
    out_load = 1'b0;
    unique case (st_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(OUT_DEPTH - 1)) begin
          init_d = 1'b0;
          st_d   = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          addr_d   = addr_i;
          sample_d = cmd_i.sample;
          case (cmd_i.op)
            CMD_ACC: begin
              if (!cmd_i.bad) begin
                mem_re = 1'b1;
                st_d   = B_ACC;
              end
            end
            CMD_READ: begin
              if (cmd_i.bad) begin
                res_d = '0;
                rst_d = 1'b1;
                st_d  = B_OUT;
              end else begin
                mem_re = 1'b1;
                st_d   = B_RDW;
              end
            end
            CMD_CLEAR: begin
              clr_d = '0;
              st_d  = B_CLEAR;
            end
            default: ;
          endcase
        end
      end
      B_ACC: begin
        mem_we = 1'b1;
        mem_wa = addr_q;
        mem_wd = rdata_q + {{(ACC_W - SMP_W){sample_q[SMP_W-1]}}, sample_q};
        st_d   = B_IDLE;
      end
      B_RDW: begin
        neg_d  = rdata_q[ACC_W-1];
        quo_d  = rdata_q[ACC_W-1] ? (~rdata_q + 1'b1) : rdata_q;
        rem_d  = '0;
        dcnt_d = '0;
        st_d   = B_DIV;
      end
      B_DIV: begin
        // Restoring division on the magnitude, one quotient bit a cycle.
        quo_d = {quo_q[ACC_W-2:0], 1'b0};
        if (shifted >= {1'b0, div_i}) begin
          rem_d    = SIZE_W'(shifted - {1'b0, div_i});
          quo_d[0] = 1'b1;
        end else begin
          rem_d = shifted[SIZE_W-1:0];
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(ACC_W - 1)) begin
          st_d = B_SAT;
        end
      end
      B_SAT: begin
        rst_d = 1'b0;
        if (neg_q) begin
          if (quo_q > ACC_W'(64'h8000_0000)) begin
            res_d = 32'h8000_0000;
          end else begin
            res_d = ~quo_q[SMP_W-1:0] + 1'b1;
          end
        end else begin
          if (quo_q > ACC_W'(64'h7FFF_FFFF)) begin
            res_d = 32'h7FFF_FFFF;
          end else begin
            res_d = quo_q[SMP_W-1:0];
          end
        end
        st_d = B_OUT;
      end
      B_OUT: begin
        if (!out_v_q || !out_stall_i) begin
          out_load = 1'b1;
          st_d     = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_CLEAR;
      init_q  <= 1'b1;
      clr_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      init_q <= init_d;
      clr_q  <= clr_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    sample_q <= sample_d;
    neg_q    <= neg_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dcnt_q   <= dcnt_d;
    res_q    <= res_d;
    rst_q    <= rst_d;
    if (out_load) begin
      mean_q   <= res_q;
      status_q <= rst_q;
    end
  end

endmodule

### hw/rtl/tensor_axis_mean.sv
// ----------------------------------------------------------------------------
// tensor_axis_mean: mean of a tensor along one axis
// Accumulates Q16.16 elements into a reduced-index accumulator memory and
// returns accumulator means on request.
// ----------------------------------------------------------------------------
// The front takes a new request only when idle: it accepts the request,
// walks the dimensions (one multiply-add each) and pushes a command into
// the queue, waiting while it is full. The back does an accumulate as a
// memory read, then a write; a read runs the bit-serial 48-step divider.
// After reset a clearing pass zeroes the accumulators; no request is
// accepted until it ends. A clear request runs the same pass.
// ----------------------------------------------------------------------------
module tensor_axis_mean import tam_pkg::*; #(
  parameter int unsigned MAX_RANK   = 4,
  parameter int unsigned MAX_EXTENT = 1024,
  parameter int unsigned OUT_DEPTH  = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [SIZE_W-1:0]       cfg_data_i,
  // Request channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [SMP_W-1:0] sample_i,
  input  logic [RIDX_W-1:0]       read_index_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SMP_W-1:0] mean_value_o,
  output logic                    status_o
);

  localparam int unsigned AW  = $clog2(OUT_DEPTH);
  localparam int unsigned LIM = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
  localparam logic [SIZE_W-1:0] EXT_CAP =
      (MAX_EXTENT > 2047) ? SIZE_W'(2047) : SIZE_W'(MAX_EXTENT);
  localparam int unsigned QW  = $bits(cmd_t) + AW;

  // Configuration registers, written at any time the port offers a transfer.
  logic [2:0]                      rank_q;
  logic [NUM_DIMS-1:0][SIZE_W-1:0] size_q;
  logic [2:0]                      axis_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= 3'd4;
      size_q <= {NUM_DIMS{SIZE_W'(1)}};
      axis_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RANK:   rank_q    <= cfg_data_i[2:0];
        CFG_SIZE_0: size_q[0] <= cfg_data_i;
        CFG_SIZE_1: size_q[1] <= cfg_data_i;
        CFG_SIZE_2: size_q[2] <= cfg_data_i;
        CFG_SIZE_3: size_q[3] <= cfg_data_i;
        CFG_AXIS:   axis_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Effective configuration: rank, extents and axis clamped into range. A
  // negative axis counts back from the rank.
  cfg_t cfg;

  always_comb begin
    logic [2:0]        r;
    logic signed [3:0] a;
    r = rank_q;
    if (r == 3'd0) r = 3'd1;
    if (r > 3'(LIM)) r = 3'(LIM);
    a = signed'({axis_q[2], axis_q});
    if (a < 0) a = a + signed'({1'b0, r});
    if (a < 0) a = '0;
    if (a >= signed'({1'b0, r})) a = signed'({1'b0, r}) - 4'sd1;
    cfg.rank = r;
    cfg.axis = a[DIM_W-1:0];
    for (int i = 0; i < NUM_DIMS; i++) begin
      cfg.size[i] = size_q[i];
      if (size_q[i] == '0) cfg.size[i] = SIZE_W'(1);
      if (size_q[i] > EXT_CAP) cfg.size[i] = EXT_CAP;
    end
  end

  // Front, queue and back.
  logic          front_busy, take, push, pop, q_full, q_empty;
  cmd_t          f_cmd, b_cmd;
  logic [AW-1:0] f_addr, b_addr;
  logic [QW-1:0] q_rdata;
  back_stat_t    bk_stat;

  assign in_stall_o = front_busy || bk_stat.init_busy;
  assign take       = in_valid_i && !in_stall_o;

  tam_front #(.OUT_DEPTH(OUT_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .req_type_i   (req_type_i),
    .sample_i     (sample_i),
    .read_index_i (read_index_i),
    .cfg_i        (cfg),
    .q_full_i     (q_full),
    .busy_o       (front_busy),
    .push_o       (push),
    .cmd_o        (f_cmd),
    .addr_o       (f_addr)
  );

  tam_fifo #(.W(QW), .DEPTH(Q_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_cmd, f_addr}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_cmd, b_addr} = q_rdata;

  tam_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (b_cmd),
    .addr_i      (b_addr),
    .div_i       (cfg.size[cfg.axis]),
    .pop_o       (pop),
    .stat_o      (bk_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_o      (mean_value_o),
    .status_o    (status_o)
  );

  // While the initial clearing pass runs nothing can have been queued, and
  // no result can be on offer.
  a_init_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.init_busy |-> q_empty)
    else $error("command queued during initial clearing pass");

  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.init_busy |-> !out_valid_o)
    else $error("result offered during initial clearing pass");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !pop |=> !q_empty)
    else $error("queue lost an entry");

endmodule
